// ===== sv/fau_pkg.sv =====
// Shared constants for the fraction arithmetic unit: field widths,
// command codes and status codes. No dependencies.
`timescale 1ns / 1ps

package fau_pkg;

   // default operand width; the top level hands it down as a parameter
   localparam int unsigned WORD_BITS_DEFAULT = 32;

   // fixed widths of the channel fields
   localparam int unsigned FIELD_BITS  = 32;
   localparam int unsigned CMD_BITS    = 2;
   localparam int unsigned STATUS_BITS = 2;

   // commands
   localparam logic [CMD_BITS-1:0] CMD_MUL    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DIV    = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_REDUCE = 2'd3;

   // result status
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

// ===== sv/fau_req_if.sv =====
// Request channel of the fraction arithmetic unit: command and two fractions.
// Depends on fau_pkg for field widths.
`timescale 1ns / 1ps

interface fau_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [fau_pkg::CMD_BITS-1:0]    command;
   logic signed [fau_pkg::FIELD_BITS-1:0]  a_num;
   logic signed [fau_pkg::FIELD_BITS-1:0]  a_den;
   logic signed [fau_pkg::FIELD_BITS-1:0]  b_num;
   logic signed [fau_pkg::FIELD_BITS-1:0]  b_den;

   modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== sv/fau_rsp_if.sv =====
// Response channel of the fraction arithmetic unit: reduced fraction and status.
// Depends on fau_pkg for field widths.
`timescale 1ns / 1ps

interface fau_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fau_pkg::FIELD_BITS-1:0]   res_num;
   logic signed [fau_pkg::FIELD_BITS-1:0]   res_den;
   logic        [fau_pkg::STATUS_BITS-1:0]  status;

   modport source (output valid, res_num, res_den, status, input ready);
   modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== sv/fau_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fau_pkg for its default width; used by fraction_arithmetic_unit for the GCD reduction.
`timescale 1ns / 1ps

module fau_divider #(
   parameter int unsigned MAG_BITS = 2 * fau_pkg::WORD_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MAG_BITS-1:0] dividend,
   input  logic [MAG_BITS-1:0] divisor,
   output logic                done,
   output logic [MAG_BITS-1:0] quotient
);

   localparam int unsigned CNT_BITS = $clog2(MAG_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MAG_BITS-1:0] quo_ff, quo_in;
   logic [MAG_BITS-1:0] rem_ff, rem_in;
   logic [MAG_BITS-1:0] dsr_ff, dsr_in;

   logic [MAG_BITS:0]   shifted;
   logic [MAG_BITS:0]   trial;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[MAG_BITS-1]};
      trial   = shifted - {1'b0, dsr_ff};
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(MAG_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[MAG_BITS]) begin
            rem_in = trial[MAG_BITS-1:0];
            quo_in = {quo_ff[MAG_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[MAG_BITS-1:0];
            quo_in = {quo_ff[MAG_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/fraction_arithmetic_unit.sv =====
// Fraction arithmetic unit: multiply, add, divide or reduce signed fractions,
// reducing each result by the GCD of its magnitudes.
// Depends on fau_pkg, fau_req_if, fau_rsp_if and fau_divider.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    command, a_num, a_den, b_num, b_den
//   rsp_if   out  valid/ready    res_num, res_den, status
//
// One beat at a time: req_if.ready is high only while the sequencer is idle.
// An item passes through three multiplies, one combine step, the binary GCD
// (subtract/shift steps, then restoring the common power of two) and two
// divisions, numerator then denominator, on the shared divider.
// Error items skip straight to the write state.
// The response sits in an output register, so a new beat is accepted while it
// waits; reset (synchronous) clears the sequencer and the response valid.
`timescale 1ns / 1ps

module fraction_arithmetic_unit #(
   parameter int unsigned WORD_BITS = fau_pkg::WORD_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   fau_req_if.sink  req_if,
   fau_rsp_if.source rsp_if
);

   localparam int unsigned MAG_BITS = 2 * WORD_BITS;
   localparam int unsigned K_BITS   = $clog2(MAG_BITS);
   localparam logic [MAG_BITS-1:0] HALF = MAG_BITS'(1) << (WORD_BITS - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_COMB  = 3'd2;
   localparam logic [2:0] ST_GCD   = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_DIVN  = 3'd5;
   localparam logic [2:0] ST_DIVD  = 3'd6;
   localparam logic [2:0] ST_WRITE = 3'd7;

   logic [2:0]                     state_ff, state_in;
   logic [1:0]                     step_ff, step_in;
   logic [fau_pkg::CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic                           err_ff, err_in;

   // operand sign and magnitude
   logic                 an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic                 an_neg_in, ad_neg_in, bn_neg_in, bd_neg_in;
   logic [WORD_BITS-1:0] an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic [WORD_BITS-1:0] an_mag_in, ad_mag_in, bn_mag_in, bd_mag_in;

   // products
   logic                prod_neg_ff [3];
   logic [MAG_BITS-1:0] prod_mag_ff [3];

   // raw result, then reduced result
   logic                rn_neg_ff, rn_neg_in, rd_neg_ff, rd_neg_in;
   logic [MAG_BITS-1:0] rn_mag_ff, rn_mag_in, rd_mag_ff, rd_mag_in;

   // GCD working registers
   logic [MAG_BITS-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [K_BITS-1:0]   k_ff, k_in;

   // response register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [fau_pkg::FIELD_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic signed [fau_pkg::FIELD_BITS-1:0] rsp_den_ff, rsp_den_in;
   logic [fau_pkg::STATUS_BITS-1:0]       rsp_status_ff, rsp_status_in;

   // shared multiplier operands
   logic                 mx_neg, my_neg;
   logic [WORD_BITS-1:0] mx_mag, my_mag;
   logic [MAG_BITS-1:0]  mul_mag;

   // adder for the add command
   logic                 sum_neg;
   logic [MAG_BITS-1:0]  sum_mag;
   logic                 ax_neg, ay_neg;
   logic [MAG_BITS-1:0]  ax_mag, ay_mag;

   // divider hookup
   logic                div_start;
   logic [MAG_BITS-1:0] div_dividend;
   logic                div_done;
   logic [MAG_BITS-1:0] div_quotient;

   // output formatting
   logic                        fits_n, fits_d;
   logic [MAG_BITS-1:0]         num_twos, den_twos;
   logic signed [WORD_BITS-1:0] num_word, den_word;
   logic                        write_go;

   logic [WORD_BITS-1:0] f_an, f_ad, f_bn, f_bd;
   logic                 req_err;

   // operand fields at accept time
   always_comb begin
      f_an = req_if.a_num[WORD_BITS-1:0];
      f_ad = req_if.a_den[WORD_BITS-1:0];
      f_bn = req_if.b_num[WORD_BITS-1:0];
      f_bd = req_if.b_den[WORD_BITS-1:0];
      req_err = (f_ad == '0)
             || (req_if.command != fau_pkg::CMD_REDUCE && f_bd == '0)
             || (req_if.command == fau_pkg::CMD_DIV && f_bn == '0);
   end

   // multiplier operand select per step
   always_comb begin
      mx_neg = ad_neg_ff;
      mx_mag = ad_mag_ff;
      my_neg = bd_neg_ff;
      my_mag = bd_mag_ff;
      case (step_ff)
         2'd0: begin
            mx_neg = an_neg_ff;
            mx_mag = an_mag_ff;
            if (cmd_ff == fau_pkg::CMD_MUL) begin
               my_neg = bn_neg_ff;
               my_mag = bn_mag_ff;
            end
         end
         2'd1: begin
            if (cmd_ff == fau_pkg::CMD_MUL) begin
               mx_neg = ad_neg_ff;
               mx_mag = ad_mag_ff;
               my_neg = bd_neg_ff;
               my_mag = bd_mag_ff;
            end else begin
               mx_neg = ad_neg_ff;
               mx_mag = ad_mag_ff;
               my_neg = bn_neg_ff;
               my_mag = bn_mag_ff;
            end
         end
         default: begin
            mx_neg = ad_neg_ff;
            mx_mag = ad_mag_ff;
            my_neg = bd_neg_ff;
            my_mag = bd_mag_ff;
         end
      endcase
      mul_mag = MAG_BITS'(mx_mag) * MAG_BITS'(my_mag);
   end

   // signed-magnitude add for the add command
   always_comb begin
      if (ad_neg_ff == bd_neg_ff && ad_mag_ff == bd_mag_ff) begin
         ax_neg = an_neg_ff;
         ax_mag = MAG_BITS'(an_mag_ff);
         ay_neg = bn_neg_ff;
         ay_mag = MAG_BITS'(bn_mag_ff);
      end else begin
         ax_neg = prod_neg_ff[0];
         ax_mag = prod_mag_ff[0];
         ay_neg = prod_neg_ff[1];
         ay_mag = prod_mag_ff[1];
      end
      if (ax_neg == ay_neg) begin
         sum_neg = ax_neg;
         sum_mag = ax_mag + ay_mag;
      end else if (ax_mag >= ay_mag) begin
         sum_neg = ax_neg;
         sum_mag = ax_mag - ay_mag;
      end else begin
         sum_neg = ay_neg;
         sum_mag = ay_mag - ax_mag;
      end
      if (sum_mag == '0) begin
         sum_neg = 1'b0;
      end
   end

   // final range check and two's complement output
   always_comb begin
      fits_n   = rn_neg_ff ? (rn_mag_ff <= HALF) : (rn_mag_ff < HALF);
      fits_d   = rd_neg_ff ? (rd_mag_ff <= HALF) : (rd_mag_ff < HALF);
      num_twos = rn_neg_ff ? (MAG_BITS'(0) - rn_mag_ff) : rn_mag_ff;
      den_twos = rd_neg_ff ? (MAG_BITS'(0) - rd_mag_ff) : rd_mag_ff;
      num_word = num_twos[WORD_BITS-1:0];
      den_word = den_twos[WORD_BITS-1:0];
      write_go = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_if.ready);
   end

   // divider start and operand
   assign div_start    = ((state_ff == ST_SHIFT) && (k_ff == '0))
                      || ((state_ff == ST_DIVN) && div_done);
   assign div_dividend = (state_ff == ST_SHIFT) ? rn_mag_ff : rd_mag_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      err_in    = err_ff;
      an_neg_in = an_neg_ff;  an_mag_in = an_mag_ff;
      ad_neg_in = ad_neg_ff;  ad_mag_in = ad_mag_ff;
      bn_neg_in = bn_neg_ff;  bn_mag_in = bn_mag_ff;
      bd_neg_in = bd_neg_ff;  bd_mag_in = bd_mag_ff;
      rn_neg_in = rn_neg_ff;  rn_mag_in = rn_mag_ff;
      rd_neg_in = rd_neg_ff;  rd_mag_in = rd_mag_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      k_in      = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in    = req_if.command;
               err_in    = req_err;
               an_neg_in = f_an[WORD_BITS-1];
               an_mag_in = f_an[WORD_BITS-1] ? (WORD_BITS'(0) - f_an) : f_an;
               ad_neg_in = f_ad[WORD_BITS-1];
               ad_mag_in = f_ad[WORD_BITS-1] ? (WORD_BITS'(0) - f_ad) : f_ad;
               bn_neg_in = f_bn[WORD_BITS-1];
               bn_mag_in = f_bn[WORD_BITS-1] ? (WORD_BITS'(0) - f_bn) : f_bn;
               bd_neg_in = f_bd[WORD_BITS-1];
               bd_mag_in = f_bd[WORD_BITS-1] ? (WORD_BITS'(0) - f_bd) : f_bd;
               step_in   = 2'd0;
               state_in  = req_err ? ST_WRITE : ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = ST_COMB;
            end
         end
         ST_COMB: begin
            case (cmd_ff)
               fau_pkg::CMD_ADD: begin
                  rn_neg_in = sum_neg;
                  rn_mag_in = sum_mag;
                  if (ad_neg_ff == bd_neg_ff && ad_mag_ff == bd_mag_ff) begin
                     rd_neg_in = ad_neg_ff;
                     rd_mag_in = MAG_BITS'(ad_mag_ff);
                  end else begin
                     rd_neg_in = prod_neg_ff[2];
                     rd_mag_in = prod_mag_ff[2];
                  end
               end
               fau_pkg::CMD_REDUCE: begin
                  rn_neg_in = an_neg_ff;
                  rn_mag_in = MAG_BITS'(an_mag_ff);
                  rd_neg_in = ad_neg_ff;
                  rd_mag_in = MAG_BITS'(ad_mag_ff);
               end
               default: begin
                  rn_neg_in = prod_neg_ff[0];
                  rn_mag_in = prod_mag_ff[0];
                  rd_neg_in = prod_neg_ff[1];
                  rd_mag_in = prod_mag_ff[1];
               end
            endcase
            gx_in    = rn_mag_in;
            gy_in    = rd_mag_in;
            k_in     = '0;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            // binary GCD, one shift or subtract per cycle; gy stays nonzero
            if (gx_ff == '0) begin
               state_in = ST_SHIFT;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               k_in  = k_ff + 1'b1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         ST_SHIFT: begin
            // restore the common power of two
            if (k_ff != '0) begin
               gy_in = gy_ff << 1;
               k_in  = k_ff - 1'b1;
            end else begin
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_done) begin
               rn_mag_in = div_quotient;
               state_in  = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_done) begin
               rd_mag_in = div_quotient;
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (write_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (write_go) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_num_in    = '0;
            rsp_den_in    = '0;
            rsp_status_in = fau_pkg::STATUS_ZERO_DEN;
         end else if (!fits_n || !fits_d) begin
            rsp_num_in    = '0;
            rsp_den_in    = '0;
            rsp_status_in = fau_pkg::STATUS_OVERFLOW;
         end else begin
            rsp_num_in    = fau_pkg::FIELD_BITS'(num_word);
            rsp_den_in    = fau_pkg::FIELD_BITS'(den_word);
            rsp_status_in = fau_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      err_ff    <= err_in;
      an_neg_ff <= an_neg_in;  an_mag_ff <= an_mag_in;
      ad_neg_ff <= ad_neg_in;  ad_mag_ff <= ad_mag_in;
      bn_neg_ff <= bn_neg_in;  bn_mag_ff <= bn_mag_in;
      bd_neg_ff <= bd_neg_in;  bd_mag_ff <= bd_mag_in;
      rn_neg_ff <= rn_neg_in;  rn_mag_ff <= rn_mag_in;
      rd_neg_ff <= rd_neg_in;  rd_mag_ff <= rd_mag_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      k_ff      <= k_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
   end

   // product register, one multiply per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_mag_ff[step_ff] <= mul_mag;
         prod_neg_ff[step_ff] <= (mul_mag != '0) && (mx_neg != my_neg);
      end
   end

   fau_divider #(
      .MAG_BITS (MAG_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gy_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.res_num = rsp_num_ff;
   assign rsp_if.res_den = rsp_den_ff;
   assign rsp_if.status  = rsp_status_ff;

endmodule
